// ===== hw/rtl/stm_pkg.sv =====
// Shared types and constants for the sorted term accumulator.
// Used by every module of the block and by its checker; depends on nothing.

package stm_pkg;

    localparam int DEF_MAX_TERMS = 32;
    localparam int COEFF_W       = 32;
    localparam int POWER_W       = 16;
    localparam int COUNT_W       = 6;
    localparam int ENT_W         = POWER_W + COEFF_W;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DUMP   = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        ST_MERGED   = 3'd0,
        ST_INSERTED = 3'd1,
        ST_DROPPED  = 3'd2,
        ST_TERM     = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_CLEARED  = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_PLACE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_EMPTY,
        S_CLEAR
    } t_state;

    typedef struct packed {
        t_status                    status;
        logic signed [COEFF_W-1:0]  coeff;
        logic signed [POWER_W-1:0]  power;
        logic [COUNT_W-1:0]         count;
        logic                       last;
    } t_result;

endpackage

// ===== hw/rtl/sorted_term_accumulator.sv =====
// Top level of the sorted term accumulator: sequencer, term memory, output register.
// Depends on stm_pkg, stm_ctrl, stm_mem and stm_outreg.
//
// Usage: a sparse polynomial is held as a table of terms sorted by descending power.
// The input channel (i_in_valid / o_in_ready) takes one request per transfer:
// insert or accumulate a term, dump all terms, or clear. The output channel
// (o_out_valid / i_out_ready) returns one result per transfer.
// Insert and clear give one result; a dump gives one result per held term, with
// o_last on the final one, or a single empty result when nothing is held.
// Timing is set by the single read port of the term memory: an insert reads
// each entry searched and each entry shifted, and a dump reads each term in turn.
// A clear or an empty dump needs no memory access. The result is offered from
// the edge that loads it, and a new request can be taken in the cycle after.
// A new request is taken only once the previous one has produced all results.
// The output register holds a result until the receiver takes it; a stalled
// receiver pauses the sequencer while the register stays full.
// Reset (synchronous, active low) empties the table at once; no clearing pass.

module sorted_term_accumulator #(
    parameter int MAX_TERMS = stm_pkg::DEF_MAX_TERMS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_req_type,
    input  logic signed [stm_pkg::COEFF_W-1:0] i_coeff_in,
    input  logic signed [stm_pkg::POWER_W-1:0] i_power_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [2:0]                         o_status,
    output logic signed [stm_pkg::COEFF_W-1:0] o_coeff_out,
    output logic signed [stm_pkg::POWER_W-1:0] o_power_out,
    output logic [stm_pkg::COUNT_W-1:0]        o_term_count,
    output logic                               o_last
);
    import stm_pkg::*;

    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W = $clog2(MAX_TERMS + 1);

    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    logic [ENT_W-1:0] mem_rd_data;
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    logic [ENT_W-1:0] mem_wr_data;
    logic             out_free;
    logic             res_load;
    t_result          res;

    stm_ctrl #(
        .MAX_TERMS (MAX_TERMS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_coeff_in    (i_coeff_in),
        .i_power_in    (i_power_in),
        .o_mem_rd_en   (mem_rd_en),
        .o_mem_rd_addr (mem_rd_addr),
        .i_mem_rd_data (mem_rd_data),
        .o_mem_wr_en   (mem_wr_en),
        .o_mem_wr_addr (mem_wr_addr),
        .o_mem_wr_data (mem_wr_data),
        .i_out_free    (out_free),
        .o_load        (res_load),
        .o_res         (res)
    );

    stm_mem #(
        .DEPTH (MAX_TERMS),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    stm_outreg u_outreg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (res_load),
        .i_res        (res),
        .o_free       (out_free),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_coeff_out  (o_coeff_out),
        .o_power_out  (o_power_out),
        .o_term_count (o_term_count),
        .o_last       (o_last)
    );

endmodule

// ===== hw/rtl/stm_mem.sv =====
// Term table storage: one write port and one read port with registered read data.
// Depends on stm_pkg for the entry width.

module stm_mem #(
    parameter int DEPTH = stm_pkg::DEF_MAX_TERMS,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [IDX_W-1:0]          i_wr_addr,
    input  logic [stm_pkg::ENT_W-1:0] i_wr_data,
    input  logic                      i_rd_en,
    input  logic [IDX_W-1:0]          i_rd_addr,
    output logic [stm_pkg::ENT_W-1:0] o_rd_data
);
    import stm_pkg::*;

    logic [ENT_W-1:0] r_mem [DEPTH];
    logic [ENT_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds until the next read, so the sequencer may wait on it.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/stm_outreg.sv =====
// Output register for result transfers; frees the sequencer from the receiver.
// Depends on stm_pkg for the result struct.

module stm_outreg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  stm_pkg::t_result                   i_res,
    output logic                               o_free,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [2:0]                         o_status,
    output logic signed [stm_pkg::COEFF_W-1:0] o_coeff_out,
    output logic signed [stm_pkg::POWER_W-1:0] o_power_out,
    output logic [stm_pkg::COUNT_W-1:0]        o_term_count,
    output logic                               o_last
);
    import stm_pkg::*;

    logic    r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_free       = !r_valid || i_out_ready;
    assign o_out_valid  = r_valid;
    assign o_status     = r_res.status;
    assign o_coeff_out  = r_res.coeff;
    assign o_power_out  = r_res.power;
    assign o_term_count = r_res.count;
    assign o_last       = r_res.last;

endmodule

// ===== hw/rtl/stm_ctrl.sv =====
// Sequencer: searches, shifts and dumps the term table through the memory port.
// Depends on stm_pkg for states, request and status codes and the result struct.

module stm_ctrl #(
    parameter int MAX_TERMS = stm_pkg::DEF_MAX_TERMS,
    parameter int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
    parameter int CNT_W     = $clog2(MAX_TERMS + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_req_type,
    input  logic signed [stm_pkg::COEFF_W-1:0] i_coeff_in,
    input  logic signed [stm_pkg::POWER_W-1:0] i_power_in,
    output logic                               o_mem_rd_en,
    output logic [IDX_W-1:0]                   o_mem_rd_addr,
    input  logic [stm_pkg::ENT_W-1:0]          i_mem_rd_data,
    output logic                               o_mem_wr_en,
    output logic [IDX_W-1:0]                   o_mem_wr_addr,
    output logic [stm_pkg::ENT_W-1:0]          o_mem_wr_data,
    input  logic                               i_out_free,
    output logic                               o_load,
    output stm_pkg::t_result                   o_res
);
    import stm_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TERMS);

    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [CNT_W-1:0]          r_idx, n_idx;
    logic [CNT_W-1:0]          r_j, n_j;
    logic signed [COEFF_W-1:0] r_coeff, n_coeff;
    logic signed [POWER_W-1:0] r_power, n_power;

    logic signed [POWER_W-1:0] rd_power;
    logic signed [COEFF_W-1:0] rd_coeff;
    logic [CNT_W-1:0]          idx_inc;
    logic [CNT_W-1:0]          j_dec;
    logic [CNT_W-1:0]          count_inc;

    // The reported count is the low bits of the held count.
    function automatic logic [COUNT_W-1:0] to_count6(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+COUNT_W-1:0] ext;
        ext = {{COUNT_W{1'b0}}, cnt};
        return ext[COUNT_W-1:0];
    endfunction

    assign rd_power  = i_mem_rd_data[ENT_W-1:COEFF_W];
    assign rd_coeff  = i_mem_rd_data[COEFF_W-1:0];
    assign idx_inc   = r_idx + 1'b1;
    assign j_dec     = r_j - 1'b1;
    assign count_inc = r_count + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_j     <= n_j;
        r_coeff <= n_coeff;
        r_power <= n_power;
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_idx         = r_idx;
        n_j           = r_j;
        n_coeff       = r_coeff;
        n_power       = r_power;
        o_in_ready    = 1'b0;
        o_mem_rd_en   = 1'b0;
        o_mem_rd_addr = r_idx[IDX_W-1:0];
        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = r_idx[IDX_W-1:0];
        o_mem_wr_data = {r_power, r_coeff};
        o_load        = 1'b0;
        o_res.status  = ST_EMPTY;
        o_res.coeff   = '0;
        o_res.power   = '0;
        o_res.count   = to_count6(r_count);
        o_res.last    = 1'b1;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_coeff = i_coeff_in;
                    n_power = i_power_in;
                    n_idx   = '0;
                    case (i_req_type)
                        REQ_INSERT: n_state = S_SRCH_RD;
                        REQ_DUMP:   n_state = (r_count == '0) ? S_EMPTY : S_DUMP_RD;
                        REQ_CLEAR:  n_state = S_CLEAR;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_SRCH_RD: begin
                if (r_idx < r_count) begin
                    o_mem_rd_en = 1'b1;
                    n_state     = S_SRCH_CMP;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_SRCH_CMP: begin
                if (rd_power > r_power) begin
                    n_idx   = idx_inc;
                    n_state = S_SRCH_RD;
                end else if (rd_power == r_power) begin
                    if (i_out_free) begin
                        o_mem_wr_en   = 1'b1;
                        o_mem_wr_data = {r_power, rd_coeff + r_coeff};
                        o_load        = 1'b1;
                        o_res.status  = ST_MERGED;
                        o_res.coeff   = rd_coeff + r_coeff;
                        o_res.power   = r_power;
                        n_state       = S_IDLE;
                    end
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                if (r_count >= MAX_CNT) begin
                    if (i_out_free) begin
                        o_load       = 1'b1;
                        o_res.status = ST_DROPPED;
                        o_res.coeff  = r_coeff;
                        o_res.power  = r_power;
                        n_state      = S_IDLE;
                    end
                end else begin
                    n_j     = r_count;
                    n_state = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: begin
                // Move entries up one place, from the top down to the insert point.
                if (r_j > r_idx) begin
                    o_mem_rd_en   = 1'b1;
                    o_mem_rd_addr = j_dec[IDX_W-1:0];
                    n_state       = S_SHIFT_WR;
                end else if (i_out_free) begin
                    o_mem_wr_en  = 1'b1;
                    n_count      = count_inc;
                    o_load       = 1'b1;
                    o_res.status = ST_INSERTED;
                    o_res.coeff  = r_coeff;
                    o_res.power  = r_power;
                    o_res.count  = to_count6(count_inc);
                    n_state      = S_IDLE;
                end
            end
            S_SHIFT_WR: begin
                o_mem_wr_en   = 1'b1;
                o_mem_wr_addr = r_j[IDX_W-1:0];
                o_mem_wr_data = i_mem_rd_data;
                n_j           = j_dec;
                n_state       = S_SHIFT_RD;
            end
            S_DUMP_RD: begin
                o_mem_rd_en = 1'b1;
                n_state     = S_DUMP_OUT;
            end
            S_DUMP_OUT: begin
                if (i_out_free) begin
                    o_load       = 1'b1;
                    o_res.status = ST_TERM;
                    o_res.coeff  = rd_coeff;
                    o_res.power  = rd_power;
                    o_res.last   = (idx_inc == r_count);
                    n_idx        = idx_inc;
                    n_state      = (idx_inc == r_count) ? S_IDLE : S_DUMP_RD;
                end
            end
            S_EMPTY: begin
                if (i_out_free) begin
                    o_load       = 1'b1;
                    o_res.status = ST_EMPTY;
                    n_state      = S_IDLE;
                end
            end
            S_CLEAR: begin
                if (i_out_free) begin
                    n_count      = '0;
                    o_load       = 1'b1;
                    o_res.status = ST_CLEARED;
                    o_res.count  = '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/stm_checker.sv =====
// Port-level checks for the sorted term accumulator, attached by a bind statement.
// Depends on stm_pkg for status codes and field widths.

module stm_checker #(
    parameter int MAX_TERMS = stm_pkg::DEF_MAX_TERMS
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic [2:0]                         o_status,
    input logic signed [stm_pkg::COEFF_W-1:0] o_coeff_out,
    input logic signed [stm_pkg::POWER_W-1:0] o_power_out,
    input logic [stm_pkg::COUNT_W-1:0]        o_term_count,
    input logic                               o_last
);
    import stm_pkg::*;

    // A stalled result must not change under the receiver.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_coeff_out) && $stable(o_power_out)
            && $stable(o_term_count) && $stable(o_last))
        else $error("result changed while stalled");

    // Only a dump emits more than one result per request.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_TERM |-> o_last)
        else $error("single-result status without last");

    // No new request is taken while a dump still has terms to emit.
    a_dump_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_TERM && !o_last |-> !o_in_ready)
        else $error("request accepted in the middle of a dump");

    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_CLEARED |-> o_term_count == '0)
        else $error("clear reported a nonzero count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (MAX_TERMS > 63) || (int'(o_term_count) <= MAX_TERMS))
        else $error("term count above table size");

endmodule

bind sorted_term_accumulator stm_checker #(.MAX_TERMS(MAX_TERMS)) u_stm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_status     (o_status),
    .o_coeff_out  (o_coeff_out),
    .o_power_out  (o_power_out),
    .o_term_count (o_term_count),
    .o_last       (o_last)
);

// ===== dv/sorted_term_accumulator_tb.sv =====
// Self-checking testbench for the sorted term accumulator: directed and random requests,
// with a scoreboard that keeps its own copy of the term table and predicts each result.
// Depends on stm_pkg and the sorted_term_accumulator top level.
`timescale 1ns / 100ps

module sorted_term_accumulator_tb;
    import stm_pkg::*;

    localparam int         TERMS         = DEF_MAX_TERMS;
    localparam int         SETTLE_CYCLES = 2 * TERMS + 16;
    localparam int         RANDOM_ITEMS  = 120;
    localparam int         MAX_REPORTS   = 10;
    localparam int         TIMEOUT_NS    = 4_000_000;
    localparam logic [1:0] REQ_UNUSED    = 2'd3;

    localparam int EP_DENSE = 0;
    localparam int EP_FILL  = 1;
    localparam int EP_NOISE = 2;

    // Shadow copy of the term table and the queue of results still owed by the block.
    class term_scoreboard;
        logic signed [POWER_W-1:0] powers [TERMS];
        logic signed [COEFF_W-1:0] coeffs [TERMS];
        int                        held;
        t_result                   awaited [$];
        int                        mismatches;

        function new();
            held       = 0;
            mismatches = 0;
        endfunction

        function void queue_result(t_status st, logic signed [COEFF_W-1:0] c,
                                   logic signed [POWER_W-1:0] p, logic fin);
            t_result r;
            r.status = st;
            r.coeff  = c;
            r.power  = p;
            r.count  = COUNT_W'(held);
            r.last   = fin;
            awaited.push_back(r);
        endfunction

        function void note_request(logic [1:0] req, logic signed [COEFF_W-1:0] c,
                                   logic signed [POWER_W-1:0] p);
            int i;
            int j;
            case (req)
                REQ_INSERT: begin
                    i = 0;
                    while (i < held && powers[i] > p) i++;
                    if (i < held && powers[i] == p) begin
                        coeffs[i] = coeffs[i] + c;
                        queue_result(ST_MERGED, coeffs[i], p, 1'b1);
                    end else if (held >= TERMS) begin
                        queue_result(ST_DROPPED, c, p, 1'b1);
                    end else begin
                        for (j = held; j > i; j--) begin
                            powers[j] = powers[j-1];
                            coeffs[j] = coeffs[j-1];
                        end
                        powers[i] = p;
                        coeffs[i] = c;
                        held++;
                        queue_result(ST_INSERTED, c, p, 1'b1);
                    end
                end
                REQ_DUMP: begin
                    if (held == 0) begin
                        queue_result(ST_EMPTY, '0, '0, 1'b1);
                    end else begin
                        for (i = 0; i < held; i++)
                            queue_result(ST_TERM, coeffs[i], powers[i], i == held - 1);
                    end
                end
                REQ_CLEAR: begin
                    held = 0;
                    queue_result(ST_CLEARED, '0, '0, 1'b1);
                end
                default: begin
                    // The unused request code leaves the table alone and gives nothing.
                end
            endcase
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (awaited.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("[%0t] unexpected result: status %0d coeff %h power %h",
                             $time, got.status, got.coeff, got.power);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (got !== want) begin
                if (mismatches < MAX_REPORTS) begin
                    $write("[%0t] result mismatch: expected status %0d coeff %h power %h ",
                           $time, want.status, want.coeff, want.power);
                    $write("count %0d last %b, ", want.count, want.last);
                    $display("got status %0d coeff %h power %h count %0d last %b",
                             got.status, got.coeff, got.power, got.count, got.last);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      i_in_valid   = 1'b0;
    logic [1:0]                i_req_type   = '0;
    logic signed [COEFF_W-1:0] i_coeff_in   = '0;
    logic signed [POWER_W-1:0] i_power_in   = '0;
    logic                      i_out_ready  = 1'b0;
    logic                      o_in_ready;
    logic                      o_out_valid;
    logic [2:0]                o_status;
    logic signed [COEFF_W-1:0] o_coeff_out;
    logic signed [POWER_W-1:0] o_power_out;
    logic [COUNT_W-1:0]        o_term_count;
    logic                      o_last;

    term_scoreboard sb;
    t_result        seen;
    int             in_idle_pct   = 0;
    int             out_stall_pct = 0;
    bit             idle_off      = 1'b0;
    int             stall_left    = 0;
    int             counted_reqs  = 0;

    sorted_term_accumulator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_coeff_in   (i_coeff_in),
        .i_power_in   (i_power_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_coeff_out  (o_coeff_out),
        .o_power_out  (o_power_out),
        .o_term_count (o_term_count),
        .o_last       (o_last)
    );

    always #4 i_clk = ~i_clk;

    // Receiver back-pressure in random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n || idle_off) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(99) < out_stall_pct) begin
            stall_left = $urandom_range(4, 0);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Both channels are sampled at the edge, so request and result transfers see
    // the values that were stable before it.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            sb.note_request(i_req_type, i_coeff_in, i_power_in);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen.status = t_status'(o_status);
            seen.coeff  = o_coeff_out;
            seen.power  = o_power_out;
            seen.count  = o_term_count;
            seen.last   = o_last;
            sb.check_result(seen);
        end
    end

    // Valid stays high between back-to-back requests; it drops only for a gap.
    task automatic send_req(logic [1:0] req, logic [COEFF_W-1:0] c, logic [POWER_W-1:0] p);
        int gap;
        if (!idle_off && $urandom_range(99) < in_idle_pct) begin
            gap = $urandom_range(5, 1);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_coeff_in <= c;
        i_power_in <= p;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (req != REQ_UNUSED) counted_reqs++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [COEFF_W-1:0] pick_coeff();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return COEFF_W'($urandom_range(8)) - 32'd4;
            default: return $urandom();
        endcase
    endfunction

    // Powers from a narrow window make merges common; the ends show up now and then.
    function automatic logic [POWER_W-1:0] near_power();
        int v;
        v = $urandom_range(6) - 3;
        case ($urandom_range(11))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return v[POWER_W-1:0];
        endcase
    endfunction

    task automatic run_episode(int mode);
        int                 n;
        logic [POWER_W-1:0] first_power;
        case (mode)
            EP_DENSE: begin
                if ($urandom_range(1) == 1) send_req(REQ_CLEAR, $urandom(), 16'($urandom()));
                n = $urandom_range(12, 4);
                repeat (n) send_req(REQ_INSERT, pick_coeff(), near_power());
                send_req(REQ_DUMP, $urandom(), 16'($urandom()));
            end
            EP_FILL: begin
                // Enough distinct powers to fill the table and overflow it, then a
                // merge into a full table.
                send_req(REQ_CLEAR, $urandom(), 16'($urandom()));
                first_power = 16'($urandom());
                send_req(REQ_INSERT, pick_coeff(), first_power);
                n = $urandom_range(37, 32);
                repeat (n) send_req(REQ_INSERT, pick_coeff(), 16'($urandom()));
                send_req(REQ_INSERT, pick_coeff(), first_power);
                send_req(REQ_DUMP, $urandom(), 16'($urandom()));
            end
            default: begin
                n = $urandom_range(10, 4);
                repeat (n)
                    send_req(2'($urandom_range(3)), $urandom(),
                             ($urandom_range(1) == 1) ? near_power() : 16'($urandom()));
            end
        endcase
    endtask

    initial begin
        int episode;
        int target;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        in_idle_pct   = 20;
        out_stall_pct = 20;
        send_req(REQ_DUMP,   '1, '1);
        send_req(REQ_CLEAR,  '0, '0);
        send_req(REQ_UNUSED, '1, '1);
        send_req(REQ_INSERT, 32'h7FFF_FFFF, 16'h7FFF);
        send_req(REQ_INSERT, 32'h0000_0001, 16'h7FFF);   // wraps to the most negative value
        send_req(REQ_INSERT, 32'h8000_0000, 16'h8000);
        send_req(REQ_INSERT, 32'h0000_0000, 16'h0000);
        send_req(REQ_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
        send_req(REQ_INSERT, 32'h0000_0001, 16'hFFFF);   // sums to zero, term is kept
        send_req(REQ_INSERT, 32'h8000_0000, 16'h8000);
        send_req(REQ_INSERT, 32'h1234_5678, 16'h0001);
        send_req(REQ_INSERT, 32'hAAAA_5555, 16'h7FFE);
        send_req(REQ_DUMP,   '0, '0);
        send_req(REQ_UNUSED, '0, '0);
        send_req(REQ_DUMP,   32'h5555_AAAA, 16'h5A5A);
        send_req(REQ_CLEAR,  '1, '1);
        send_req(REQ_DUMP,   '0, '0);
        send_req(REQ_INSERT, 32'h5555_AAAA, 16'h8001);
        send_req(REQ_INSERT, 32'h0000_0002, 16'h8000);
        send_req(REQ_DUMP,   '0, '0);
        drain();

        target  = counted_reqs + RANDOM_ITEMS;
        episode = 0;
        while (counted_reqs < target) begin
            in_idle_pct   = ($urandom_range(2) == 0) ? 0 : $urandom_range(40, 10);
            out_stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(40, 10);
            run_episode((episode == 0) ? EP_FILL : $urandom_range(EP_NOISE));
            if ($urandom_range(3) == 0) drain();
            episode++;
        end

        idle_off = 1'b1;
        run_episode(EP_DENSE);
        drain();

        if (sb.awaited.size() != 0) sb.mismatches++;
        if (sb.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
